// ===== rtl/adab_pkg.sv =====
// adab_pkg: types, constants and arithmetic helpers of the AdaBound update engine.
// No dependencies; imported by every module under rtl/.
package adab_pkg;

  localparam int NUM_PARAMS_DEF = 4096;

  // pipeline geometry
  localparam int ST_VS  = 3;                       // stage that holds the new second moment
  localparam int SQ_ST  = 14;                      // root stages, two result bits each
  localparam int DV_ST  = 16;                      // quotient stages, two bits each but one bit in the last
  localparam int ST_DIV = ST_VS + SQ_ST + 1 + DV_ST;
  localparam int NST    = ST_DIV + 3;

  localparam logic [24:0] Q_ONE = 25'h100_0000;

  // register map
  localparam logic [2:0] REG_BETA1   = 3'd0;
  localparam logic [2:0] REG_BETA2   = 3'd1;
  localparam logic [2:0] REG_RATE    = 3'd2;
  localparam logic [2:0] REG_LOW     = 3'd3;
  localparam logic [2:0] REG_HIGH    = 3'd4;
  localparam logic [2:0] REG_DECAY   = 3'd5;
  localparam logic [2:0] REG_EPSILON = 3'd6;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [11:0] param_index;
    logic [31:0] grad_or_value;
    logic        decay_mask;
    logic        last_in_range;
  } in_t;

  typedef struct packed {
    logic [11:0] out_index;
    logic [31:0] new_param;
    logic        out_last;
    logic        saturated;
  } out_t;

  typedef struct packed {
    logic [23:0] beta_first;
    logic [23:0] beta_second;
    logic [30:0] step_rate;
    logic [30:0] rate_low_bound;
    logic [30:0] rate_high_bound;
    logic [30:0] decay_weight;
    logic [30:0] epsilon_add;
  } cfg_t;

  typedef struct packed {
    logic [31:0] p;
    logic [31:0] m;
    logic [30:0] v;
  } mw_t;

  typedef struct packed {
    logic        load;
    logic [11:0] index;
    logic        mask;
    logic        last;
    logic [31:0] g;
    logic [31:0] p;
    logic [31:0] m;
    logic [30:0] v;
  } item_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [27:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] den;
    logic [32:0] rem;
    logic [30:0] quo;
    logic        ovf;
  } dv_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clamp;
  } sat_t;

  function automatic sat_t sat48(logic signed [47:0] x);
    sat_t o;
    if (x > $signed(48'h0000_7FFF_FFFF)) begin
      o.val   = 32'h7FFF_FFFF;
      o.clamp = 1'b1;
    end else if (x < $signed(48'hFFFF_8000_0000)) begin
      o.val   = 32'h8000_0000;
      o.clamp = 1'b1;
    end else begin
      o.val   = x[31:0];
      o.clamp = 1'b0;
    end
    return o;
  endfunction

  // one digit of the restoring square root
  function automatic sq_t sqrt_step(sq_t s, logic [1:0] pair);
    logic [31:0] r2;
    logic [31:0] trial;
    sq_t         o;
    r2    = {s.rem[29:0], pair};
    trial = {2'b00, s.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[26:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[26:0], 1'b0};
    end
    return o;
  endfunction

  // one bit of the restoring divider
  function automatic dv_t div_step(dv_t s, logic b);
    logic [32:0] r2;
    dv_t         o;
    o  = s;
    r2 = {s.rem[31:0], b};
    if (r2 >= {1'b0, s.den}) begin
      o.rem = r2 - {1'b0, s.den};
      o.quo = {s.quo[29:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {s.quo[29:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/adab_sqrt_pipe.sv =====
// adab_sqrt_pipe: pipelined integer square root of v * 2^24, two result bits per stage.
// Depends on adab_pkg.
module adab_sqrt_pipe
  import adab_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] vs_in,
  output logic [27:0] root_out
);

  sq_t         st_r [SQ_ST];
  logic [30:0] vs_r [SQ_ST];

  for (genvar k = 0; k < SQ_ST; k++) begin : g_stage
    sq_t         base;
    sq_t         mid;
    sq_t         fin;
    logic [30:0] vsrc;
    logic [55:0] x;
    if (k == 0) begin : g_head
      assign base = '0;
      assign vsrc = vs_in;
    end else begin : g_body
      assign base = st_r[k-1];
      assign vsrc = vs_r[k-1];
    end
    assign x   = {1'b0, vsrc, 24'd0};
    assign mid = sqrt_step(base, x[55-4*k -: 2]);
    assign fin = sqrt_step(mid, x[53-4*k -: 2]);
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= fin;
        vs_r[k] <= vsrc;
      end
    end
  end

  assign root_out = st_r[SQ_ST-1].root;

endmodule

// ===== rtl/adab_div_pipe.sv =====
// adab_div_pipe: pipelined rate / (root + eps) in Q8.24, 31 quotient bits plus overflow flag.
// Depends on adab_pkg.
module adab_div_pipe
  import adab_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [27:0] root,
  input  logic [30:0] eps,
  input  logic [30:0] rate,
  output logic [30:0] quo,
  output logic        ovf
);

  dv_t         st_r [DV_ST+1];
  dv_t         head;
  logic [54:0] num;

  assign num = {rate, 24'd0};

  // quotient of 2^31 or more, or a zero divisor, sets the overflow flag; the top then substitutes the high bound
  always_comb begin
    head.den = 32'(root) + 32'(eps);
    head.ovf = (32'(rate[30:7]) >= head.den);
    head.rem = 33'(rate[30:7]);
    head.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= head;
    end
  end

  for (genvar k = 1; k <= DV_ST; k++) begin : g_stage
    dv_t mid;
    dv_t fin;
    assign mid = div_step(st_r[k-1], num[32-2*k]);
    if (31 - 2*k >= 0) begin : g_two
      assign fin = div_step(mid, num[31-2*k]);
    end else begin : g_one
      assign fin = mid;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= fin;
      end
    end
  end

  assign quo = st_r[DV_ST].quo;
  assign ovf = st_r[DV_ST].ovf;

endmodule

// ===== rtl/adabound_param_update.sv =====
// adabound_param_update: AdaBound per-parameter update engine, Q8.24 fixed point.
// Depends on adab_pkg, adab_sqrt_pipe and adab_div_pipe.
//
// Usage:
//   in_*  : valid/ready channel of update or load transactions (in_t).
//   out_* : valid/ready channel, one result transaction (out_t) per input.
//   cfg_* : APB-style register port, pready tied high, registers at 4*index.
// Throughput: one transaction per cycle through a 37-stage pipeline that
//   holds the square root and divide units, unless a stall, a hazard or the
//   reset clear holds the input. A transaction whose parameter is still in
//   that pipeline waits until the earlier one writes back.
// Reset: synchronous, active low. After reset the moment store is cleared,
//   one entry per cycle until all NUM_PARAMS entries are clear; in_ready stays low meanwhile.
//   The user must write registers only while the block is idle; the block itself does not enforce this.
// Stall: when out_ready is low with a result held, the whole pipeline halts
//   and in_ready drops; the held result is kept until taken.
module adabound_param_update
  import adab_pkg::*;
#(
  parameter int NUM_PARAMS = NUM_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int          AW   = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam logic [31:0] NP32 = 32'(NUM_PARAMS);

  cfg_t cfg_r;

  mw_t  store_r [NUM_PARAMS];
  mw_t  rd_q;
  mw_t  wb;

  logic          clearing_r;
  logic [AW-1:0] clr_idx_r;

  logic          vld_r  [NST];
  logic [AW-1:0] addr_r [NST];
  item_t         item_r [NST];

  logic signed [57:0] pm1_r;
  logic signed [57:0] pm2_r;
  logic signed [63:0] gsq_r;
  logic        [54:0] pv1_r;
  logic        [54:0] pv1_r2;
  logic        [44:0] pvlo_r;
  logic        [43:0] pvhi_r;
  logic        [30:0] q_r;
  logic signed [63:0] tq_r;
  logic signed [63:0] tw_r;

  logic          out_vld_r;
  out_t          out_q_r;
  out_t          out_nxt;

  logic          en;
  logic          hazard;
  logic          accept;
  logic [11:0]   idx_mod;
  logic [AW-1:0] in_addr;
  logic [24:0]   cb1;
  logic [24:0]   cb2;
  logic signed [58:0] msum;
  sat_t          msat;
  logic [63:0]   vsum;
  logic [30:0]   vs;
  logic [27:0]   root;
  logic [30:0]   quo;
  logic          ovf;
  logic [30:0]   q_nxt;
  logic signed [39:0] tqs;
  logic signed [39:0] tws;
  logic signed [47:0] tsum;
  sat_t          psat;
  item_t         last_it;
  item_t         st1_nxt;
  item_t         st2_nxt;
  item_t         st3_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  mw_t           wr_data;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beta_first      <= 24'd15099494;
      cfg_r.beta_second     <= 24'd16760439;
      cfg_r.step_rate       <= 31'd16777;
      cfg_r.rate_low_bound  <= 31'd0;
      cfg_r.rate_high_bound <= 31'h7FFF_FFFF;
      cfg_r.decay_weight    <= 31'd0;
      cfg_r.epsilon_add     <= 31'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[4:2])
        REG_BETA1:   cfg_r.beta_first      <= cfg_pwdata[23:0];
        REG_BETA2:   cfg_r.beta_second     <= cfg_pwdata[23:0];
        REG_RATE:    cfg_r.step_rate       <= cfg_pwdata[30:0];
        REG_LOW:     cfg_r.rate_low_bound  <= cfg_pwdata[30:0];
        REG_HIGH:    cfg_r.rate_high_bound <= cfg_pwdata[30:0];
        REG_DECAY:   cfg_r.decay_weight    <= cfg_pwdata[30:0];
        REG_EPSILON: cfg_r.epsilon_add     <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_BETA1:   cfg_prdata = {8'd0, cfg_r.beta_first};
      REG_BETA2:   cfg_prdata = {8'd0, cfg_r.beta_second};
      REG_RATE:    cfg_prdata = {1'b0, cfg_r.step_rate};
      REG_LOW:     cfg_prdata = {1'b0, cfg_r.rate_low_bound};
      REG_HIGH:    cfg_prdata = {1'b0, cfg_r.rate_high_bound};
      REG_DECAY:   cfg_prdata = {1'b0, cfg_r.decay_weight};
      REG_EPSILON: cfg_prdata = {1'b0, cfg_r.epsilon_add};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- input side ----------------
  // index modulo the store depth by shifted compare-subtract
  always_comb begin
    idx_mod = in_data.param_index;
    for (int k = 11; k >= 0; k--) begin
      if ({20'd0, idx_mod} >= (NP32 << k)) begin
        idx_mod = idx_mod - 12'(NP32 << k);
      end
    end
  end
  assign in_addr = AW'(idx_mod);

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NST; k++) begin
      if (vld_r[k] && (addr_r[k] == in_addr)) begin
        hazard = 1'b1;
      end
    end
  end

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en && !clearing_r && !hazard;
  assign accept   = in_valid && in_ready;

  // ---------------- store ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      if (clr_idx_r == AW'(NUM_PARAMS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign last_it = item_r[NST-1];
  assign wr_en   = clearing_r || (en && vld_r[NST-1]);
  assign wr_addr = clearing_r ? clr_idx_r : addr_r[NST-1];
  assign wr_data = clearing_r ? mw_t'('0) : wb;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_q <= store_r[in_addr];
    end
  end

  // ---------------- pipeline control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= accept;
      for (int k = 1; k < NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------- datapath ----------------
  assign cb1 = Q_ONE - {1'b0, cfg_r.beta_first};
  assign cb2 = Q_ONE - {1'b0, cfg_r.beta_second};

  always_comb begin
    msum = pm1_r + pm2_r;
    msat = sat48(48'($signed(msum[58:24])));
    vsum = 64'(pv1_r2) + 64'(pvlo_r) + (64'(pvhi_r) << 20);
    vs   = (|vsum[63:55]) ? 31'h7FFF_FFFF : vsum[54:24];
  end

  always_comb begin
    st1_nxt   = item_r[0];
    st1_nxt.p = rd_q.p;
    st1_nxt.m = rd_q.m;
    st1_nxt.v = rd_q.v;
    st2_nxt   = item_r[1];
    st2_nxt.m = msat.val;
    st3_nxt   = item_r[2];
    st3_nxt.v = vs;
  end

  adab_sqrt_pipe u_sqrt (
    .clk      (clk),
    .en       (en),
    .vs_in    (item_r[ST_VS].v),
    .root_out (root)
  );

  adab_div_pipe u_div (
    .clk  (clk),
    .en   (en),
    .root (root),
    .eps  (cfg_r.epsilon_add),
    .rate (cfg_r.step_rate),
    .quo  (quo),
    .ovf  (ovf)
  );

  always_comb begin
    q_nxt = ovf ? cfg_r.rate_high_bound : quo;
    if (q_nxt > cfg_r.rate_high_bound) begin
      q_nxt = cfg_r.rate_high_bound;
    end
    if (q_nxt < cfg_r.rate_low_bound) begin
      q_nxt = cfg_r.rate_low_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr_r[0]          <= in_addr;
      item_r[0].load     <= in_data.req_type;
      item_r[0].index    <= in_data.param_index;
      item_r[0].mask     <= in_data.decay_mask;
      item_r[0].last     <= in_data.last_in_range;
      item_r[0].g        <= in_data.grad_or_value;
      item_r[0].p        <= '0;
      item_r[0].m        <= '0;
      item_r[0].v        <= '0;
      for (int k = 1; k < NST; k++) begin
        addr_r[k] <= addr_r[k-1];
      end
      item_r[1] <= st1_nxt;
      item_r[2] <= st2_nxt;
      item_r[3] <= st3_nxt;
      for (int k = 4; k < NST; k++) begin
        item_r[k] <= item_r[k-1];
      end

      pm1_r  <= $signed({1'b0, cfg_r.beta_first}) * $signed(rd_q.m);
      pm2_r  <= $signed({1'b0, cb1}) * $signed(item_r[0].g);
      gsq_r  <= $signed(item_r[0].g) * $signed(item_r[0].g);
      pv1_r  <= cfg_r.beta_second * rd_q.v;
      pv1_r2 <= pv1_r;
      pvlo_r <= cb2 * gsq_r[43:24];
      pvhi_r <= cb2 * gsq_r[62:44];
      q_r    <= q_nxt;
      tq_r   <= $signed({1'b0, q_r}) * $signed(item_r[ST_DIV+1].m);
      tw_r   <= $signed({1'b0, cfg_r.decay_weight}) * $signed(item_r[ST_DIV+1].p);
    end
  end

  // ---------------- writeback and result ----------------
  always_comb begin
    tqs  = tq_r[63:24];
    tws  = tw_r[63:24];
    tsum = 48'(tqs) + (last_it.mask ? 48'(tws) : 48'sd0);
    psat = sat48(48'($signed(last_it.p)) - tsum);
    if (last_it.load == REQ_LOAD) begin
      wb.p              = last_it.g;
      wb.m              = '0;
      wb.v              = '0;
      out_nxt.saturated = 1'b0;
    end else begin
      wb.p              = psat.val;
      wb.m              = last_it.m;
      wb.v              = last_it.v;
      out_nxt.saturated = psat.clamp;
    end
    out_nxt.out_index = last_it.index;
    out_nxt.new_param = wb.p;
    out_nxt.out_last  = last_it.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

endmodule

// ===== rtl/adab_checker.sv =====
// adab_checker: port-level assertions for adabound_param_update, bound to the top level.
// Depends on adab_pkg and adabound_param_update.
module adab_checker
  import adab_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data,
  input logic cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not empty after reset");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.new_param == 32'h7FFF_FFFF) || (out_data.new_param == 32'h8000_0000))
    else $error("saturated flag without a clamped value");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind adabound_param_update adab_checker u_adab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);

// ===== verif/tb_adabound_param_update.sv =====
// Testbench for adabound_param_update: APB register phases plus streamed update/load
// transactions, checked against a built-in fixed-point AdaBound predictor.
// Depends on adab_pkg and the rtl/ sources.
`timescale 1ns / 1ps

module tb_adabound_param_update;
  import adab_pkg::*;

  localparam int NPAR = 4096;
  localparam int N_RAND = 1400;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  adabound_param_update u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0] b1_q, b2_q;
  logic [30:0] rate_q, low_q, high_q, wd_q, eps_q;
  logic signed [31:0] p_mem [NPAR];
  logic signed [31:0] m_mem [NPAR];
  logic [30:0]        v_mem [NPAR];

  in_t  pending_txn [$];
  out_t expected_results [$];
  int   mismatches = 0;
  longint cycles = 0;
  bit   quiet = 0;
  bit   hold_send = 0;
  int   idle_in = 0;
  logic in_ready_q = 1'b0;
  bit   loaded_sched [NPAR];

  function automatic longint floor24(longint x);
    return x >>> 24;
  endfunction

  function automatic longint isqrt(longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= x) r += 64'd1 << b;
    return r;
  endfunction

  function automatic out_t adabound_predict(in_t t);
    out_t o;
    int a;
    longint g, m, v, gg, p, root, den, q, tt, res;
    a = t.param_index;
    g = longint'($signed(t.grad_or_value));
    o.out_index = t.param_index;
    o.out_last = t.last_in_range;
    o.saturated = 1'b0;
    if (t.req_type == REQ_LOAD) begin
      p_mem[a] = t.grad_or_value;
      m_mem[a] = 0;
      v_mem[a] = 0;
      o.new_param = t.grad_or_value;
    end else begin
      m = floor24(longint'(b1_q) * longint'(m_mem[a]) +
                  (64'sd16777216 - longint'(b1_q)) * g);
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      if (m < -64'sd2147483648) m = -64'sd2147483648;
      gg = (g * g) >> 24;
      v = (longint'(b2_q) * longint'(v_mem[a]) +
           (64'sd16777216 - longint'(b2_q)) * gg) >> 24;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      root = isqrt(v << 24);
      den = root + eps_q;
      q = (den == 0) ? longint'(high_q) : (longint'(rate_q) << 24) / den;
      if (q > high_q) q = high_q;
      if (q < low_q) q = low_q;
      p = p_mem[a];
      tt = floor24(q * m);
      if (t.decay_mask) tt += floor24(longint'(wd_q) * p);
      res = p - tt;
      if (res > 64'sd2147483647) begin res = 64'sd2147483647; o.saturated = 1'b1; end
      if (res < -64'sd2147483648) begin res = -64'sd2147483648; o.saturated = 1'b1; end
      m_mem[a] = m[31:0];
      v_mem[a] = v[30:0];
      p_mem[a] = res[31:0];
      o.new_param = res[31:0];
    end
    return o;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_ready_q)) begin
      if (idle_in > 0) begin
        idle_in <= idle_in - 1;
        in_valid <= 1'b0;
      end else if (pending_txn.size() > 0 && !hold_send) begin
        in_data <= pending_txn.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 19) == 0) idle_in <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end
  always @(posedge clk) in_ready_q <= in_ready && in_valid;

  // expectations are formed at acceptance so state order matches the block
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(adabound_predict(in_data));
  end

  int idle_out = 0;
  always @(negedge clk) begin
    if (quiet) out_ready <= 1'b1;
    else if (idle_out > 0) begin
      idle_out <= idle_out - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      idle_out <= $urandom_range(1, 13);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch idx %0d: exp %h/%0d/%0d got %h/%0d/%0d",
            want.out_index, want.new_param, want.out_last, want.saturated,
            out_data.new_param, out_data.out_last, out_data.saturated);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[adabound_param_update] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_BETA1: b1_q = val[23:0];
      REG_BETA2: b2_q = val[23:0];
      REG_RATE: rate_q = val[30:0];
      REG_LOW: low_q = val[30:0];
      REG_HIGH: high_q = val[30:0];
      REG_DECAY: wd_q = val[30:0];
      REG_EPSILON: eps_q = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_txn.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  function automatic in_t make_txn(logic kind, int idx, logic [31:0] val);
    in_t t;
    t.req_type = kind;
    t.param_index = idx[11:0];
    t.grad_or_value = val;
    t.decay_mask = $urandom_range(0, 1);
    t.last_in_range = $urandom_range(0, 1);
    return t;
  endfunction

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  // queue n transactions over parameters lo_idx..hi_idx, loading any not yet loaded and reloading others at random
  task automatic add_batch(int n, int lo_idx, int hi_idx);
    int a;
    for (int k = 0; k < n; k++) begin
      a = $urandom_range(lo_idx, hi_idx);
      if (!loaded_sched[a] || $urandom_range(0, 15) == 0) begin
        pending_txn.push_back(make_txn(REQ_LOAD, a, rand_grad()));
        loaded_sched[a] = 1;
      end else pending_txn.push_back(make_txn(REQ_UPDATE, a, rand_grad()));
    end
  endtask

  logic [31:0] cfg_sets [4][7];

  initial begin
    b1_q = 24'd15099494; b2_q = 24'd16760439; rate_q = 31'd16777;
    low_q = 0; high_q = 31'h7FFF_FFFF; wd_q = 0; eps_q = 31'd1;
    for (int i = 0; i < NPAR; i++) begin
      m_mem[i] = 0; v_mem[i] = 0; p_mem[i] = 0; loaded_sched[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: extremes, loads, both bounds, top index
    pending_txn.push_back(make_txn(REQ_LOAD, 0, 32'h0100_0000));
    pending_txn.push_back(make_txn(REQ_LOAD, 4095, 32'h7FFF_FFFF));
    pending_txn.push_back(make_txn(REQ_LOAD, 1, 32'h8000_0000));
    pending_txn.push_back(make_txn(REQ_UPDATE, 0, 32'h0000_0000));
    pending_txn.push_back(make_txn(REQ_UPDATE, 4095, 32'h8000_0000));
    pending_txn.push_back(make_txn(REQ_UPDATE, 1, 32'h7FFF_FFFF));
    pending_txn.push_back(make_txn(REQ_UPDATE, 0, 32'hFFFF_FFFF));
    pending_txn.push_back(make_txn(REQ_UPDATE, 4095, 32'h7FFF_FFFF));
    drain();

    // register settings: extremes, zero denominator, crossed bounds, decay
    cfg_sets[0] = '{32'hFF_FFFF, 32'hFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 0};
    cfg_sets[1] = '{0, 0, 32'h0100_0000, 32'h0200_0000, 32'h0001_0000,
                    32'h0001_0000, 32'h7FFF_FFFF};
    cfg_sets[2] = '{32'hE6_6666, 32'hFF_BE77, 32'h0000_4189, 32'h0000_1000,
                    32'h0400_0000, 32'h0000_0100, 32'd1};
    cfg_sets[3] = '{32'hFFFF_FFFF, 32'h80_0000, 32'hFFFF_FFFF, 32'h10,
                    32'h0100_0000, 32'h0010_0000, 32'h100};
    for (int s = 0; s < 5; s++) begin
      for (int r = 0; r < 7; r++)
        cfg_write(r[2:0], s < 4 ? cfg_sets[s][r] : $urandom);
      pending_txn.push_back(make_txn(REQ_UPDATE, 0, 32'h0000_0000));
      add_batch(N_RAND / 6, 0, s == 1 ? 7 : 4095);
      if (s == 2) begin
        wait (pending_txn.size() < 100);
        hold_send = 1;
        wait (expected_results.size() == 0);
        hold_send = 0;
      end
      drain();
    end
    for (int r = 0; r < 7; r++) cfg_write(r[2:0], cfg_sets[2][r]);
    quiet = 1;
    add_batch(N_RAND / 6, 0, 63);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[adabound_param_update] OK");
    end else begin
      $display("[adabound_param_update] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/adab_pkg.sv
rtl/adab_sqrt_pipe.sv
rtl/adab_div_pipe.sv
rtl/adabound_param_update.sv
rtl/adab_checker.sv
verif/tb_adabound_param_update.sv
